/* sv/pasa_pkg.sv */
// ----------------------------------------------------------------------------
// pasa_pkg - shared types and constants of the activity slot arbiter
// Holds state codes, operation codes, slot entry layout, bar sizes and the
// easing step used by the bar animation.
// ----------------------------------------------------------------------------
package pasa_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    // configuration port
    localparam int          APB_ADDR_W      = 2;
    localparam int          APB_DATA_W      = 32;
    localparam logic [1:0]  REG_ROTATE_ADDR = 2'd0;
    localparam logic [15:0] ROTATE_RESET    = 16'd3000;

    // activity kinds
    localparam logic [2:0] KIND_NONE       = 3'd0;
    localparam logic [2:0] KIND_MUSIC      = 3'd1;
    localparam logic [2:0] KIND_DOWNLOAD   = 3'd2;
    localparam logic [2:0] KIND_AI         = 3'd3;
    localparam logic [2:0] KIND_BACKGROUND = 3'd4;
    localparam logic [2:0] KIND_VOICE      = 3'd5;
    localparam logic [2:0] KIND_NOTIFY     = 3'd6;
    localparam logic [2:0] KIND_TIMER      = 3'd7;

    // bar geometry
    localparam logic [8:0] BAR_W_IDLE = 9'd200;
    localparam logic [5:0] BAR_H_IDLE = 6'd36;
    localparam logic [9:0] EASE_ROUND = 10'd3;
    localparam logic [9:0] EASE_SNAP  = 10'd4;
    localparam int         EASE_SHIFT = 2;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_DISMISS = 2'd1,
        OP_TICK    = 2'd2,
        OP_NOP     = 2'd3
    } pasa_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEEK,
        ST_PUSH_WR,
        ST_DISMISS,
        ST_TICK,
        ST_SCAN,
        ST_SCAN_END,
        ST_CHK_RD,
        ST_CHK,
        ST_FILL_CHK,
        ST_EASE,
        ST_DONE
    } pasa_state_t;

    typedef enum logic [2:0] {
        SCAN_ROTATE,
        SCAN_DROP,
        SCAN_FILL,
        SEEK_FREE,
        SEEK_OCC
    } pasa_scan_t;

    typedef struct packed {
        logic [3:0]  pri;
        logic [31:0] start;
        logic [31:0] life;
    } slot_entry_t;

    typedef struct packed {
        logic [8:0] width;
        logic [5:0] height;
    } bar_size_t;

    function automatic bar_size_t bar_target(input logic [2:0] kind);
        bar_size_t s;
        case (kind)
            KIND_MUSIC:      s = '{width: 9'd400, height: 6'd44};
            KIND_DOWNLOAD:   s = '{width: 9'd350, height: 6'd44};
            KIND_AI:         s = '{width: 9'd400, height: 6'd44};
            KIND_BACKGROUND: s = '{width: 9'd300, height: 6'd40};
            KIND_VOICE:      s = '{width: 9'd400, height: 6'd52};
            KIND_NOTIFY:     s = '{width: 9'd350, height: 6'd44};
            KIND_TIMER:      s = '{width: 9'd250, height: 6'd40};
            default:         s = '{width: BAR_W_IDLE, height: BAR_H_IDLE};
        endcase
        return s;
    endfunction

    // One easing step: move a quarter of the gap (rounded up), snap when
    // growing and the gap is under four.
    function automatic logic [8:0] ease_step(input logic [8:0] shown,
                                             input logic [8:0] target);
        logic [9:0] d;
        logic [9:0] step;
        logic [8:0] r;
        d    = '0;
        step = '0;
        r    = shown;
        if (target > shown) begin
            d    = {1'b0, target} - {1'b0, shown};
            step = (d + EASE_ROUND) >> EASE_SHIFT;
            r    = (d < EASE_SNAP) ? target : shown + step[8:0];
        end
        else if (target < shown) begin
            d    = {1'b0, shown} - {1'b0, target};
            step = (d + EASE_ROUND) >> EASE_SHIFT;
            r    = shown - step[8:0];
        end
        return r;
    endfunction

endpackage

/* sv/pasa_in_if.sv */
// ----------------------------------------------------------------------------
// pasa_in_if - command channel of the activity slot arbiter
// Valid/ready channel carrying one push, dismiss or tick command.
// ----------------------------------------------------------------------------
interface pasa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [2:0]  activity_kind;
    logic [3:0]  activity_priority;
    logic [31:0] lifetime_ms;
    logic [31:0] now_ms;

    modport source (
        output valid,
        output operation,
        output activity_kind,
        output activity_priority,
        output lifetime_ms,
        output now_ms,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  activity_kind,
        input  activity_priority,
        input  lifetime_ms,
        input  now_ms,
        output ready
    );
endinterface

/* sv/pasa_out_if.sv */
// ----------------------------------------------------------------------------
// pasa_out_if - result channel of the activity slot arbiter
// Valid/ready channel carrying the selection and bar size after a command.
// ----------------------------------------------------------------------------
interface pasa_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       current_valid;
    logic [2:0] current_slot;
    logic [2:0] current_kind;
    logic [8:0] bar_width;
    logic [5:0] bar_height;

    modport source (
        output valid,
        output accepted,
        output current_valid,
        output current_slot,
        output current_kind,
        output bar_width,
        output bar_height,
        input  ready
    );

    modport sink (
        input  valid,
        input  accepted,
        input  current_valid,
        input  current_slot,
        input  current_kind,
        input  bar_width,
        input  bar_height,
        output ready
    );
endinterface

/* sv/pasa_slot_mem.sv */
// ----------------------------------------------------------------------------
// pasa_slot_mem - slot entry store
// Priority, start time and lifetime of each slot; one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module pasa_slot_mem #(
    parameter int SLOT_COUNT = pasa_pkg::SLOT_COUNT_DEF,
    localparam int IDX_W     = $clog2(SLOT_COUNT)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [IDX_W-1:0]      waddr,
    input  pasa_pkg::slot_entry_t wdata,
    input  logic [IDX_W-1:0]      raddr,
    output pasa_pkg::slot_entry_t rdata
);
    import pasa_pkg::*;

    slot_entry_t mem [SLOT_COUNT];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/pasa_age_unit.sv */
// ----------------------------------------------------------------------------
// pasa_age_unit - shared elapsed-time comparator
// Modular 32-bit subtract of a reference time from now, compared against a
// limit; serves both the rotate check and the per-slot expiry check.
// ----------------------------------------------------------------------------
module pasa_age_unit (
    input  logic [31:0] now,
    input  logic [31:0] since,
    input  logic [31:0] limit,
    output logic        over
);
    logic [31:0] elapsed;

    // wraps modulo 2^32 by construction
    assign elapsed = now - since;
    assign over    = elapsed > limit;

endmodule

/* sv/priority_activity_slot_arbiter.sv */
// ----------------------------------------------------------------------------
// priority_activity_slot_arbiter - activity slot table with priority selection
// Keeps a table of activities, selects the current one by priority on push,
// first occupied slot on dismissal and periodic priority reselection, expires
// old entries on ticks and eases an animated bar toward the current activity's size.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  cmd      | in  | valid/ready        | operation, kind, priority, life, now
//  result   | out | valid/ready        | accepted, selection, bar size
//  apb      | in  | psel/penable/pready| rotate_period_ms at byte address 0
//
//  Steps per command, from the accepting edge to the result load:
//    push    seeks the first free slot, then writes it if one was found
//    dismiss frees the selected slot, if any, then seeks the first occupied slot
//    tick    checks the rotate period and the selection, scans the table as
//            needed to rotate, drop or fill, then takes one easing step
//    no-op and push of kind zero go straight to the result load
//  A table scan reads and judges one slot per cycle through the slot store's
//  single read port and the shared age comparator.
//  Reset (rst_n, asynchronous) empties the table and clears the selection.
//  A stalled result holds in the output register while the next command
//  is already taken.
// ----------------------------------------------------------------------------
module priority_activity_slot_arbiter #(
    parameter int SLOT_COUNT = pasa_pkg::SLOT_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pasa_in_if.sink                         cmd,
    pasa_out_if.source                      result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pasa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pasa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pasa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import pasa_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [15:0] period_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ROTATE_ADDR) ? {16'b0, period_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= ROTATE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == REG_ROTATE_ADDR)
        begin
            period_reg <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    pasa_state_t      state_reg, state_next;
    pasa_scan_t       purpose_reg, purpose_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;

    // latched command
    logic [2:0]  kind_in_reg, kind_in_next;
    logic [3:0]  pri_in_reg, pri_in_next;
    logic [31:0] life_in_reg, life_in_next;
    logic [31:0] now_reg, now_next;

    // selection
    logic             sel_valid_reg, sel_valid_next;
    logic [IDX_W-1:0] sel_idx_reg, sel_idx_next;
    logic [31:0]      last_sel_reg, last_sel_next;
    logic             accepted_reg, accepted_next;

    // scan results
    logic             best_found_reg, best_found_next;
    logic [3:0]       top_pri_reg, top_pri_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;

    // bar animation
    logic [8:0] shown_w_reg, shown_w_next;
    logic [5:0] shown_h_reg, shown_h_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic       out_acc_reg, out_acc_next;
    logic       out_cv_reg, out_cv_next;
    logic [2:0] out_slot_reg, out_slot_next;
    logic [2:0] out_kind_reg, out_kind_next;
    logic [8:0] out_w_reg, out_w_next;
    logic [5:0] out_h_reg, out_h_next;

    // slot kinds live in flops so reset empties the table at once
    logic [2:0]       kind_reg [SLOT_COUNT];
    logic             kind_we;
    logic [IDX_W-1:0] kind_waddr;
    logic [2:0]       kind_wdata;

    // slot store ports
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_entry_t      mem_wdata;
    logic [IDX_W-1:0] rd_addr;
    slot_entry_t      rd_entry;

    // shared age comparator ports
    logic [31:0] age_since;
    logic [31:0] age_limit;
    logic        age_over;

    logic             cmd_xfer;
    logic             out_xfer;
    logic [IDX_W-1:0] cnt_idx;
    logic [IDX_W-1:0] eval_idx;
    logic             scan_last;
    logic             seek_last;
    logic             seek_match;
    logic [2:0]       sel_kind;
    logic [2:0]       eval_kind;
    logic             rd_expired;
    bar_size_t        target;

    assign cmd_xfer   = cmd.valid && cmd.ready;
    assign out_xfer   = result.valid && result.ready;
    assign cnt_idx    = scan_cnt_reg[IDX_W-1:0];
    assign eval_idx   = IDX_W'(scan_cnt_reg - CNT_W'(1));
    assign scan_last  = (scan_cnt_reg == CNT_W'(SLOT_COUNT));
    assign seek_last  = (scan_cnt_reg == CNT_W'(SLOT_COUNT - 1));
    assign sel_kind   = kind_reg[sel_idx_reg];
    assign eval_kind  = kind_reg[eval_idx];
    assign seek_match = (purpose_reg == SEEK_FREE) ? (kind_reg[cnt_idx] == KIND_NONE)
                                                   : (kind_reg[cnt_idx] != KIND_NONE);
    assign rd_expired = age_over && (rd_entry.life != 32'd0);
    assign target     = bar_target(sel_valid_reg ? sel_kind : KIND_NONE);

    // Read the slot under scan during a scan, otherwise keep the current
    // selection's entry on the read port.
    assign rd_addr = (state_reg == ST_SCAN && !scan_last) ? cnt_idx : sel_idx_reg;

    // The comparator times the selection age on the tick entry cycle and a
    // slot's age everywhere else.
    assign age_since = (state_reg == ST_TICK) ? last_sel_reg : rd_entry.start;
    assign age_limit = (state_reg == ST_TICK) ? {16'b0, period_reg} : rd_entry.life;

    pasa_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    pasa_age_unit u_age_unit (
        .now   (now_reg),
        .since (age_since),
        .limit (age_limit),
        .over  (age_over)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    case (pasa_op_t'(cmd.operation))
                        OP_PUSH:    state_next = (cmd.activity_kind != KIND_NONE) ? ST_SEEK
                                                                                  : ST_DONE;
                        OP_DISMISS: state_next = ST_DISMISS;
                        OP_TICK:    state_next = ST_TICK;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_SEEK:
            begin
                if (seek_match || seek_last)
                begin
                    state_next = (purpose_reg == SEEK_FREE) ? ST_PUSH_WR : ST_DONE;
                end
            end
            ST_PUSH_WR:  state_next = ST_DONE;
            ST_DISMISS:  state_next = sel_valid_reg ? ST_SEEK : ST_DONE;
            ST_TICK:     state_next = age_over ? ST_SCAN : ST_CHK_RD;
            ST_SCAN:     state_next = scan_last ? ST_SCAN_END : ST_SCAN;
            ST_SCAN_END:
            begin
                case (purpose_reg)
                    SCAN_ROTATE: state_next = ST_CHK_RD;
                    SCAN_DROP:   state_next = ST_FILL_CHK;
                    default:     state_next = ST_EASE;
                endcase
            end
            ST_CHK_RD:   state_next = sel_valid_reg ? ST_CHK : ST_FILL_CHK;
            ST_CHK:
            begin
                state_next = (sel_kind == KIND_NONE || rd_expired) ? ST_SCAN : ST_FILL_CHK;
            end
            ST_FILL_CHK: state_next = sel_valid_reg ? ST_EASE : ST_SCAN;
            ST_EASE:     state_next = ST_DONE;
            ST_DONE:     state_next = (!out_valid_reg || result.ready) ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and table writes
    // ------------------------------------------------------------------
    always_comb
    begin
        purpose_next    = purpose_reg;
        scan_cnt_next   = scan_cnt_reg;
        kind_in_next    = kind_in_reg;
        pri_in_next     = pri_in_reg;
        life_in_next    = life_in_reg;
        now_next        = now_reg;
        sel_valid_next  = sel_valid_reg;
        sel_idx_next    = sel_idx_reg;
        last_sel_next   = last_sel_reg;
        accepted_next   = accepted_reg;
        best_found_next = best_found_reg;
        top_pri_next    = top_pri_reg;
        best_idx_next   = best_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        shown_w_next    = shown_w_reg;
        shown_h_next    = shown_h_reg;
        out_valid_next  = out_valid_reg && !out_xfer;
        out_acc_next    = out_acc_reg;
        out_cv_next     = out_cv_reg;
        out_slot_next   = out_slot_reg;
        out_kind_next   = out_kind_reg;
        out_w_next      = out_w_reg;
        out_h_next      = out_h_reg;
        kind_we         = 1'b0;
        kind_waddr      = sel_idx_reg;
        kind_wdata      = KIND_NONE;
        mem_we          = 1'b0;
        mem_waddr       = hit_idx_reg;
        mem_wdata       = '{pri: pri_in_reg, start: now_reg, life: life_in_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    kind_in_next  = cmd.activity_kind;
                    pri_in_next   = cmd.activity_priority;
                    life_in_next  = cmd.lifetime_ms;
                    now_next      = cmd.now_ms;
                    accepted_next = 1'b0;
                    hit_next      = 1'b0;
                    scan_cnt_next = '0;
                    purpose_next  = SEEK_FREE;
                end
            end

            ST_SEEK:
            begin
                // one slot per cycle: first free for a push, first occupied
                // after a dismiss
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (seek_match)
                begin
                    if (purpose_reg == SEEK_FREE)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cnt_idx;
                    end
                    else
                    begin
                        sel_valid_next = 1'b1;
                        sel_idx_next   = cnt_idx;
                    end
                end
            end

            ST_PUSH_WR:
            begin
                // rd_entry holds the current selection's entry here
                if (hit_reg)
                begin
                    kind_we       = 1'b1;
                    kind_waddr    = hit_idx_reg;
                    kind_wdata    = kind_in_reg;
                    mem_we        = 1'b1;
                    accepted_next = 1'b1;
                    if (!sel_valid_reg || pri_in_reg > rd_entry.pri)
                    begin
                        sel_valid_next = 1'b1;
                        sel_idx_next   = hit_idx_reg;
                        last_sel_next  = now_reg;
                    end
                end
            end

            ST_DISMISS:
            begin
                if (sel_valid_reg)
                begin
                    kind_we        = 1'b1;
                    sel_valid_next = 1'b0;
                    sel_idx_next   = '0;
                    scan_cnt_next  = '0;
                    purpose_next   = SEEK_OCC;
                end
            end

            ST_TICK:
            begin
                if (age_over)
                begin
                    scan_cnt_next   = '0;
                    purpose_next    = SCAN_ROTATE;
                    best_found_next = 1'b0;
                    top_pri_next    = '0;
                    best_idx_next   = '0;
                end
            end

            ST_SCAN:
            begin
                // issue the next slot's address while judging the slot read last cycle
                if (!scan_last)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (scan_cnt_reg != '0 && eval_kind != KIND_NONE)
                begin
                    if (rd_expired)
                    begin
                        kind_we    = 1'b1;
                        kind_waddr = eval_idx;
                    end
                    else if (!best_found_reg || rd_entry.pri > top_pri_reg)
                    begin
                        best_found_next = 1'b1;
                        top_pri_next    = rd_entry.pri;
                        best_idx_next   = eval_idx;
                    end
                end
            end

            ST_SCAN_END:
            begin
                case (purpose_reg)
                    SCAN_ROTATE:
                    begin
                        if (best_found_reg && (!sel_valid_reg || best_idx_reg != sel_idx_reg))
                        begin
                            sel_valid_next = 1'b1;
                            sel_idx_next   = best_idx_reg;
                            last_sel_next  = now_reg;
                        end
                    end
                    SCAN_DROP:
                    begin
                        sel_valid_next = best_found_reg;
                        sel_idx_next   = best_found_reg ? best_idx_reg : '0;
                    end
                    default:
                    begin
                        sel_valid_next = best_found_reg;
                        sel_idx_next   = best_found_reg ? best_idx_reg : '0;
                        last_sel_next  = now_reg;
                    end
                endcase
            end

            ST_CHK:
            begin
                // drop a selection that is gone or has run out, then rescan
                if (sel_kind == KIND_NONE || rd_expired)
                begin
                    kind_we         = 1'b1;
                    scan_cnt_next   = '0;
                    purpose_next    = SCAN_DROP;
                    best_found_next = 1'b0;
                    top_pri_next    = '0;
                    best_idx_next   = '0;
                end
            end

            ST_FILL_CHK:
            begin
                if (!sel_valid_reg)
                begin
                    scan_cnt_next   = '0;
                    purpose_next    = SCAN_FILL;
                    best_found_next = 1'b0;
                    top_pri_next    = '0;
                    best_idx_next   = '0;
                end
            end

            ST_EASE:
            begin
                shown_w_next = ease_step(shown_w_reg, target.width);
                shown_h_next = 6'(ease_step({3'b0, shown_h_reg}, {3'b0, target.height}));
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = accepted_reg;
                    out_cv_next    = sel_valid_reg;
                    out_slot_next  = sel_valid_reg ? 3'(sel_idx_reg) : 3'd0;
                    out_kind_next  = sel_valid_reg ? sel_kind : KIND_NONE;
                    out_w_next     = shown_w_reg;
                    out_h_next     = shown_h_reg;
                end
            end

            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            purpose_reg    <= SEEK_FREE;
            scan_cnt_reg   <= '0;
            sel_valid_reg  <= 1'b0;
            sel_idx_reg    <= '0;
            last_sel_reg   <= '0;
            accepted_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            shown_w_reg    <= BAR_W_IDLE;
            shown_h_reg    <= BAR_H_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            purpose_reg    <= purpose_next;
            scan_cnt_reg   <= scan_cnt_next;
            sel_valid_reg  <= sel_valid_next;
            sel_idx_reg    <= sel_idx_next;
            last_sel_reg   <= last_sel_next;
            accepted_reg   <= accepted_next;
            best_found_reg <= best_found_next;
            hit_reg        <= hit_next;
            shown_w_reg    <= shown_w_next;
            shown_h_reg    <= shown_h_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        kind_in_reg  <= kind_in_next;
        pri_in_reg   <= pri_in_next;
        life_in_reg  <= life_in_next;
        now_reg      <= now_next;
        top_pri_reg  <= top_pri_next;
        best_idx_reg <= best_idx_next;
        hit_idx_reg  <= hit_idx_next;
        out_acc_reg  <= out_acc_next;
        out_cv_reg   <= out_cv_next;
        out_slot_reg <= out_slot_next;
        out_kind_reg <= out_kind_next;
        out_w_reg    <= out_w_next;
        out_h_reg    <= out_h_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                kind_reg[i] <= KIND_NONE;
            end
        end
        else if (kind_we)
        begin
            kind_reg[kind_waddr] <= kind_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign cmd.ready            = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.accepted      = out_acc_reg;
    assign result.current_valid = out_cv_reg;
    assign result.current_slot  = out_slot_reg;
    assign result.current_kind  = out_kind_reg;
    assign result.bar_width     = out_w_reg;
    assign result.bar_height    = out_h_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_sel_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && sel_valid_reg) |-> (kind_reg[sel_idx_reg] != KIND_NONE))
        else $error("selected slot is empty between commands");

    a_idle_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !sel_valid_reg) |-> (sel_idx_reg == '0))
        else $error("selection index not cleared while nothing is selected");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= CNT_W'(SLOT_COUNT))
        else $error("slot scan counter ran past the table");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> !cmd.ready)
        else $error("command taken while previous one is in work");
`endif

endmodule

/* tb/priority_activity_slot_arbiter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_activity_slot_arbiter_tb - self-checking bench for the slot arbiter
// Drives push, dismiss, tick and idle commands over the command channel,
// predicts every result transfer with an independent model of the slot table,
// selection and bar easing, and checks each result field by field. The rotate
// period is rewritten over APB between phases, with read-back.
// ----------------------------------------------------------------------------
module priority_activity_slot_arbiter_tb;
    import pasa_pkg::*;

    localparam int SLOTS            = SLOT_COUNT_DEF;
    localparam int HALF_PERIOD      = 4;
    localparam int RESET_CYCLES     = 12;
    localparam int GAP_PERCENT      = 23;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 180;
    localparam int DRAIN_CYCLES     = 60;
    localparam int WATCHDOG_NS      = 5_000_000;

    // One command transfer as the bench sees it.
    typedef struct packed {
        pasa_op_t    op;
        logic [2:0]  kind;
        logic [3:0]  pri;
        logic [31:0] life;
        logic [31:0] now;
    } activity_cmd_t;

    // One result transfer: selection and bar size after a command.
    typedef struct {
        logic       accepted;
        logic       current_valid;
        logic [2:0] current_slot;
        logic [2:0] current_kind;
        logic [8:0] bar_width;
        logic [5:0] bar_height;
    } selection_view_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the slot table and selection, turns
    // every accepted command into the expected view and checks the views that
    // come out in order.
    // ------------------------------------------------------------------------
    class selection_scoreboard;
        logic [15:0]     rotate_ms;
        logic [2:0]      slot_kinds[SLOTS];
        logic [3:0]      slot_pris[SLOTS];
        logic [31:0]     slot_starts[SLOTS];
        logic [31:0]     slot_lives[SLOTS];
        bit              picked;
        int unsigned     picked_slot;
        logic [31:0]     picked_at;
        int unsigned     shown_w;
        int unsigned     shown_h;
        selection_view_t pending_views[$];
        int unsigned     mismatches;

        function new();
            rotate_ms = ROTATE_RESET;
            foreach (slot_kinds[i])
            begin
                slot_kinds[i]  = KIND_NONE;
                slot_pris[i]   = '0;
                slot_starts[i] = '0;
                slot_lives[i]  = '0;
            end
            picked      = 1'b0;
            picked_slot = 0;
            picked_at   = '0;
            shown_w     = BAR_W_IDLE;
            shown_h     = BAR_H_IDLE;
            mismatches  = 0;
        endfunction

        function void set_rotate(logic [15:0] period);
            rotate_ms = period;
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
                mismatches++;
            end
        endfunction

        // A lifetime of zero never runs out; the age wraps modulo 2^32.
        function bit aged(int unsigned i, logic [31:0] now);
            logic [31:0] held;
            held = now - slot_starts[i];
            return (slot_lives[i] != 0) && (held > slot_lives[i]);
        endfunction

        // Free aged entries and find the highest priority; ties keep the lower
        // slot. best is left alone when nothing is occupied.
        function bit pick_highest(logic [31:0] now, inout int unsigned best);
            bit         found;
            logic [3:0] top_pri;
            found   = 1'b0;
            top_pri = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_kinds[i] == KIND_NONE)
                    continue;
                if (aged(i, now))
                begin
                    slot_kinds[i] = KIND_NONE;
                    continue;
                end
                if (!found || slot_pris[i] > top_pri)
                begin
                    found   = 1'b1;
                    top_pri = slot_pris[i];
                    best    = i;
                end
            end
            return found;
        endfunction

        // Move a quarter of the gap, rounded up; snap only when growing.
        function int unsigned ease_toward(int unsigned shown, int unsigned target);
            int unsigned gap;
            if (target > shown)
            begin
                gap = target - shown;
                return (gap < 4) ? target : shown + (gap + 3) / 4;
            end
            if (target < shown)
            begin
                gap = shown - target;
                return shown - (gap + 3) / 4;
            end
            return shown;
        endfunction

        function void advance_clock(logic [31:0] now);
            int unsigned best;
            int unsigned tw;
            int unsigned th;
            logic [31:0] since;
            best  = 0;
            tw    = BAR_W_IDLE;
            th    = BAR_H_IDLE;
            since = now - picked_at;
            // rotation: reselect by priority once the period has passed
            if (since > rotate_ms)
            begin
                if (pick_highest(now, best) && (!picked || best != picked_slot))
                begin
                    picked      = 1'b1;
                    picked_slot = best;
                    picked_at   = now;
                end
            end
            // drop a current entry that is gone or aged out
            if (picked && (slot_kinds[picked_slot] == KIND_NONE || aged(picked_slot, now)))
            begin
                slot_kinds[picked_slot] = KIND_NONE;
                picked      = pick_highest(now, best);
                picked_slot = picked ? best : 0;
            end
            // fill an empty selection
            if (!picked)
            begin
                picked      = pick_highest(now, best);
                picked_slot = picked ? best : 0;
                picked_at   = now;
            end
            if (picked)
            begin
                case (slot_kinds[picked_slot])
                    KIND_MUSIC:      begin tw = 400; th = 44; end
                    KIND_DOWNLOAD:   begin tw = 350; th = 44; end
                    KIND_AI:         begin tw = 400; th = 44; end
                    KIND_BACKGROUND: begin tw = 300; th = 40; end
                    KIND_VOICE:      begin tw = 400; th = 52; end
                    KIND_NOTIFY:     begin tw = 350; th = 44; end
                    KIND_TIMER:      begin tw = 250; th = 40; end
                    default:         ;
                endcase
            end
            shown_w = ease_toward(shown_w, tw);
            shown_h = ease_toward(shown_h, th);
        endfunction

        function void note_command(activity_cmd_t c);
            selection_view_t v;
            bit              took;
            took = 1'b0;
            case (c.op)
                OP_PUSH:
                begin
                    if (c.kind != KIND_NONE)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (slot_kinds[i] != KIND_NONE)
                                continue;
                            slot_kinds[i]  = c.kind;
                            slot_pris[i]   = c.pri;
                            slot_starts[i] = c.now;
                            slot_lives[i]  = c.life;
                            took = 1'b1;
                            if (!picked || c.pri > slot_pris[picked_slot])
                            begin
                                picked      = 1'b1;
                                picked_slot = i;
                                picked_at   = c.now;
                            end
                            break;
                        end
                    end
                end
                OP_DISMISS:
                begin
                    if (picked)
                    begin
                        slot_kinds[picked_slot] = KIND_NONE;
                        picked      = 1'b0;
                        picked_slot = 0;
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (slot_kinds[i] != KIND_NONE)
                            begin
                                picked      = 1'b1;
                                picked_slot = i;
                                break;
                            end
                        end
                    end
                end
                OP_TICK:
                    advance_clock(c.now);
                default:
                    ;
            endcase
            v.accepted      = took;
            v.current_valid = picked;
            v.current_slot  = picked ? 3'(picked_slot) : 3'd0;
            v.current_kind  = picked ? slot_kinds[picked_slot] : KIND_NONE;
            v.bar_width     = 9'(shown_w);
            v.bar_height    = 6'(shown_h);
            pending_views.push_back(v);
        endfunction

        function void check_result(selection_view_t got);
            selection_view_t want;
            if (pending_views.size() == 0)
            begin
                $display("%0t: result transfer with no expectation pending", $time);
                mismatches++;
                return;
            end
            want = pending_views.pop_front();
            compare_field("accepted",      want.accepted,      got.accepted);
            compare_field("current_valid", want.current_valid, got.current_valid);
            compare_field("current_slot",  want.current_slot,  got.current_slot);
            compare_field("current_kind",  want.current_kind,  got.current_kind);
            compare_field("bar_width",     want.bar_width,     got.bar_width);
            compare_field("bar_height",    want.bar_height,    got.bar_height);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pasa_in_if  cmd_if ();
    pasa_out_if res_if ();

    bit                  sender_gaps;
    bit                  receiver_stalls;
    logic [31:0]         clock_ms;
    selection_scoreboard scoreboard;

    always #(HALF_PERIOD) clk = ~clk;

    priority_activity_slot_arbiter uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Receiver: stall the result channel at random, changing at the falling edge.
    always @(negedge clk)
        res_if.ready <= !(receiver_stalls && $urandom_range(0, 99) < GAP_PERCENT);

    // Monitors: note each command transfer and check each result transfer at
    // the rising edge where it happens.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
                scoreboard.note_command(activity_cmd_t'{pasa_op_t'(cmd_if.operation),
                    cmd_if.activity_kind, cmd_if.activity_priority,
                    cmd_if.lifetime_ms, cmd_if.now_ms});
            if (res_if.valid && res_if.ready)
                scoreboard.check_result(selection_view_t'{res_if.accepted,
                    res_if.current_valid, res_if.current_slot, res_if.current_kind,
                    res_if.bar_width, res_if.bar_height});
        end
    end

    // Present one command and hold it until the block takes it. Insert random
    // idle cycles ahead of it while sender gaps are enabled.
    task automatic issue_command(input pasa_op_t op, input logic [2:0] kind,
                                 input logic [3:0] pri, input logic [31:0] life,
                                 input logic [31:0] now);
        @(negedge clk);
        while (sender_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            cmd_if.valid = 1'b0;
            @(negedge clk);
        end
        cmd_if.valid             = 1'b1;
        cmd_if.operation         = op;
        cmd_if.activity_kind     = kind;
        cmd_if.activity_priority = pri;
        cmd_if.lifetime_ms       = life;
        cmd_if.now_ms            = now;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
    endtask

    // Mostly well-formed traffic: time moves forward in small steps, with rare
    // long jumps and rare arbitrary values so that the wrap and every bit of
    // now_ms are exercised. Lifetimes are short enough that entries age out.
    task automatic send_random_activity(input int unsigned push_share);
        int unsigned roll;
        pasa_op_t    op;
        logic [31:0] life;
        roll = $urandom_range(0, 99);
        if (roll < push_share)
            op = OP_PUSH;
        else if (roll < push_share + 12)
            op = OP_DISMISS;
        else if (roll < 95)
            op = OP_TICK;
        else
            op = OP_NOP;
        case ($urandom_range(0, 9))
            0, 1:    life = '0;
            2:       life = $urandom_range(1, 40);
            3:       life = $urandom();
            default: life = $urandom_range(1, 3000);
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 3)
            clock_ms = $urandom();
        else if (roll < 10)
            clock_ms += $urandom_range(3000, 70000);
        else
            clock_ms += $urandom_range(0, 300);
        issue_command(op, ($urandom_range(0, 19) == 0) ? KIND_NONE : 3'($urandom_range(1, 7)),
                      4'($urandom_range(0, 15)), life, clock_ms);
    endtask

    // Drop valid and hold the sender until every expected result has arrived.
    task automatic settle();
        @(negedge clk);
        cmd_if.valid = 1'b0;
        while (scoreboard.pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB read of the rotate period, compared with the expected value.
    task automatic check_rotate_readback(input logic [15:0] period);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = REG_ROTATE_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        scoreboard.compare_field("rotate_period_ms read-back", {16'd0, period}, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // APB write: setup cycle, then access cycle; the register loads at the
    // edge where the access completes. Read back right after.
    task automatic write_rotate_period(input logic [15:0] period);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_ROTATE_ADDR;
        pwdata  = {16'd0, period};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        scoreboard.set_rotate(period);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_rotate_readback(period);
    endtask

    initial
    begin
        int unsigned push_share;

        // Drive every input to a known value before reset is released.
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        cmd_if.valid             = 1'b0;
        cmd_if.operation         = OP_NOP;
        cmd_if.activity_kind     = KIND_NONE;
        cmd_if.activity_priority = '0;
        cmd_if.lifetime_ms       = '0;
        cmd_if.now_ms            = '0;
        res_if.ready             = 1'b0;
        sender_gaps              = 1'b1;
        receiver_stalls          = 1'b1;
        clock_ms                 = '0;
        scoreboard               = new();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The rotate period must come out of reset at its default.
        check_rotate_readback(ROTATE_RESET);

        // ---- directed part ----
        // Empty table: dismiss does nothing, a tick keeps the idle bar, and
        // the no-operation code just reports state (all-ones payload).
        issue_command(OP_DISMISS, KIND_NONE, 4'd0, 32'd0, 32'd0);
        issue_command(OP_TICK, KIND_NONE, 4'd0, 32'd0, 32'd5);
        issue_command(OP_NOP, KIND_TIMER, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // A push of kind zero cannot take a slot.
        issue_command(OP_PUSH, KIND_NONE, 4'd9, 32'd100, 32'd6);
        // Fill all eight slots with every kind: priority extremes, a tie that
        // must not win, lifetimes from never to the maximum.
        issue_command(OP_PUSH, KIND_MUSIC, 4'd0, 32'd0, 32'd10);
        issue_command(OP_PUSH, KIND_DOWNLOAD, 4'd15, 32'hFFFF_FFFF, 32'd11);
        issue_command(OP_PUSH, KIND_AI, 4'd15, 32'd100, 32'd12);
        issue_command(OP_PUSH, KIND_BACKGROUND, 4'd7, 32'd40, 32'd13);
        issue_command(OP_PUSH, KIND_VOICE, 4'd3, 32'd0, 32'd14);
        issue_command(OP_PUSH, KIND_NOTIFY, 4'd1, 32'd1, 32'd15);
        issue_command(OP_PUSH, KIND_TIMER, 4'd8, 32'd2000, 32'd16);
        issue_command(OP_PUSH, KIND_VOICE, 4'd0, 32'd0, 32'd17);
        // Table full: this push is dropped.
        issue_command(OP_PUSH, KIND_AI, 4'd15, 32'd0, 32'd18);
        // Ease toward the current size; push and dismiss leave the bar alone.
        issue_command(OP_TICK, KIND_NONE, 4'd0, 32'd0, 32'd20);
        issue_command(OP_TICK, KIND_NONE, 4'd0, 32'd0, 32'd60);
        issue_command(OP_DISMISS, KIND_NONE, 4'd0, 32'd0, 32'd61);
        // Past the rotate period: reselect by priority and age out entries.
        issue_command(OP_TICK, KIND_NONE, 4'd0, 32'd0, 32'd3020);
        issue_command(OP_TICK, KIND_NONE, 4'd0, 32'd0, 32'd3022);
        // Wrap of the millisecond counter: the entry ages out one past its life.
        issue_command(OP_PUSH, KIND_TIMER, 4'd15, 32'h20, 32'hFFFF_FFF0);
        issue_command(OP_TICK, KIND_NONE, 4'd0, 32'd0, 32'h10);
        issue_command(OP_TICK, KIND_NONE, 4'd0, 32'd0, 32'h11);
        // Drain the table by dismissal, then ease back toward idle.
        issue_command(OP_DISMISS, KIND_NONE, 4'd0, 32'd0, 32'h12);
        issue_command(OP_DISMISS, KIND_NONE, 4'd0, 32'd0, 32'h13);
        issue_command(OP_DISMISS, KIND_NONE, 4'd0, 32'd0, 32'h14);
        issue_command(OP_TICK, KIND_NONE, 4'd0, 32'd0, 32'h15);
        settle();

        // ---- random part, one rotate setting per phase ----
        clock_ms = 32'h100;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1: write_rotate_period(16'd0);
                2:
                begin
                    // longest period, and a stretch with no idling at all
                    write_rotate_period(16'hFFFF);
                    sender_gaps     = 1'b0;
                    receiver_stalls = 1'b0;
                end
                3:
                begin
                    write_rotate_period(16'd250);
                    sender_gaps     = 1'b1;
                    receiver_stalls = 1'b1;
                end
                4: write_rotate_period(16'd1);
                default: ;
            endcase
            // push-heavy phase keeps the table full more often
            push_share = (phase == 3) ? 55 : 34;
            repeat (RANDOM_PER_PHASE) send_random_activity(push_share);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (scoreboard.mismatches == 0 && scoreboard.pending_views.size() == 0)
            $display("** priority_activity_slot_arbiter: PASSED **");
        else
            $display("** priority_activity_slot_arbiter: FAILED **");
        $finish;
    end

    // Watchdog: a stuck handshake ends the run here.
    initial
    begin
        #(WATCHDOG_NS);
        $display("** priority_activity_slot_arbiter: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
sv/pasa_pkg.sv
sv/pasa_in_if.sv
sv/pasa_out_if.sv
sv/pasa_slot_mem.sv
sv/pasa_age_unit.sv
sv/priority_activity_slot_arbiter.sv
tb/priority_activity_slot_arbiter_tb.sv
